FILE: sv/frequency_ranked_counter_table_unit_defines.svh
// ----------------------------------------------------------------------------
// frequency ranked counter table unit: assertion macros
// shared property forms for the counter table checks
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_RANKED_COUNTER_TABLE_UNIT_DEFINES_SVH
`define FREQUENCY_RANKED_COUNTER_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define FRCT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define FRCT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/frct_pkg.sv
// ----------------------------------------------------------------------------
// frct_pkg
// field widths, stream packing, codes and the cell control bundle
// ----------------------------------------------------------------------------
package frct_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   // request fields
   localparam int CMD_W      = 1;
   localparam int KEY_W      = 64;
   localparam int RANK_W     = 4;
   localparam int REQ_DATA_W = 72;
   localparam int REQ_KEY_LO  = 0;
   localparam int REQ_RANK_LO = KEY_W;

   // result fields
   localparam int STATUS_W    = 3;
   localparam int POS_W       = 4;
   localparam int COUNT_OUT_W = 32;
   localparam int FILL_OUT_W  = 5;
   localparam int RSP_USED_W  = POS_W + KEY_W + COUNT_OUT_W + FILL_OUT_W;
   localparam int RSP_DATA_W  = 112;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_USED_W;

   localparam logic CMD_COUNT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED = 3'd0,
      STATUS_INCR     = 3'd1,
      STATUS_EMPTY    = 3'd2,
      STATUS_FULL     = 3'd3,
      STATUS_READ_OK  = 3'd4,
      STATUS_BEYOND   = 3'd5
   } frct_status_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic look;     // compare cycle of an accepted transfer
      logic is_read;  // compare by rank instead of by key
      logic upd;      // shift cycle that changes the table
      logic insert;   // shift opens a slot for a new key
   } frct_ctl_type;

endpackage

FILE: sv/frct_cell.sv
// ----------------------------------------------------------------------------
// frct_cell
// one table slot: key and count, compare logic and neighbor shift
// ----------------------------------------------------------------------------
module frct_cell #(
   parameter int CELL_INDEX  = 0,
   parameter int DEPTH       = frct_pkg::DEPTH_DEFAULT,
   parameter int COUNT_WIDTH = frct_pkg::COUNT_WIDTH_DEFAULT,
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int FILL_W = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  frct_pkg::frct_ctl_type        ctl,
   input  logic [frct_pkg::KEY_W-1:0]    req_key,
   input  logic [frct_pkg::RANK_W-1:0]   req_rank,
   input  logic [FILL_W-1:0]             fill,
   input  logic [IDX_W-1:0]              hit_idx,
   input  logic [frct_pkg::KEY_W-1:0]    new_key,
   input  logic [COUNT_WIDTH-1:0]        new_count,
   input  logic                          prev_span,
   input  logic [frct_pkg::KEY_W-1:0]    prev_key,
   input  logic [COUNT_WIDTH-1:0]        prev_count,
   output logic                          sel,
   output logic                          span,
   output logic                          dst,
   output logic [frct_pkg::KEY_W-1:0]    key,
   output logic [COUNT_WIDTH-1:0]        count
);

   localparam int CMP_W = (IDX_W > frct_pkg::RANK_W) ? IDX_W : frct_pkg::RANK_W;

   logic [frct_pkg::KEY_W-1:0] key_ff, key_in;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   logic                       hit_ff;
   logic                       occ, rank_eq, below_hit, gt_new, is_one, at_fill;

   assign occ       = FILL_W'(CELL_INDEX) < fill;
   assign rank_eq   = CMP_W'(CELL_INDEX) == CMP_W'(req_rank);
   assign below_hit = IDX_W'(CELL_INDEX) < hit_idx;
   assign gt_new    = count_ff > new_count;
   assign is_one    = count_ff == COUNT_WIDTH'(1);
   assign at_fill   = fill == FILL_W'(CELL_INDEX);

   assign sel = occ && (ctl.is_read ? rank_eq : (key_ff == req_key));

   // slots that take part in the shift form one contiguous run
   always_comb begin
      if (ctl.insert) begin
         span = (occ && is_one) || at_fill;
      end else begin
         span = hit_ff || (below_hit && !gt_new);
      end
   end

   assign dst = span && !prev_span;

   always_comb begin
      key_in   = key_ff;
      count_in = count_ff;
      if (ctl.upd) begin
         priority if (dst) begin
            key_in   = new_key;
            count_in = new_count;
         end else if (span) begin
            key_in   = prev_key;
            count_in = prev_count;
         end else begin
            // outside the shifted run the slot keeps its entry
            key_in   = key_ff;
            count_in = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
      if (ctl.look) begin
         hit_ff <= sel;
      end
   end

   assign key   = key_ff;
   assign count = count_ff;

endmodule

FILE: sv/frequency_ranked_counter_table_unit.sv
// a request is compared in the cell row at its transfer; its result is registered in the shift cycle
// requests are taken one at a time, a compare cycle then a shift cycle in the cell row
// a waiting result holds the shift cycle until rsp_tready frees the output register
// reset: synchronous, clears fill level, state and result valid; cell contents are not cleared
// ----------------------------------------------------------------------------
// frequency_ranked_counter_table_unit
// keyed occurrence counter kept sorted by descending count in a row of cells
// ----------------------------------------------------------------------------
`include "frequency_ranked_counter_table_unit_defines.svh"

module frequency_ranked_counter_table_unit #(
   parameter int DEPTH       = frct_pkg::DEPTH_DEFAULT,
   parameter int COUNT_WIDTH = frct_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [frct_pkg::REQ_DATA_W-1:0]   req_tdata,  // key[63:0], rank[67:64], zero pad
   input  logic [frct_pkg::CMD_W-1:0]        req_tuser,  // command[0]
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [frct_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // position[3:0], key_out[67:4],
                                                         // count_out[99:68],
                                                         // fill_out[104:100], zero pad
   output logic [frct_pkg::STATUS_W-1:0]     rsp_tuser   // status[2:0]
);

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int KEY_W  = frct_pkg::KEY_W;

   typedef enum logic {ST_IDLE, ST_UPD} state_type;

   // request field split
   logic                          req_cmd;
   logic [KEY_W-1:0]              req_key;
   logic [frct_pkg::RANK_W-1:0]   req_rank;

   assign req_cmd  = req_tuser[0];
   assign req_key  = req_tdata[frct_pkg::REQ_KEY_LO +: KEY_W];
   assign req_rank = req_tdata[frct_pkg::REQ_RANK_LO +: frct_pkg::RANK_W];

   // control state
   state_type                     state_ff, state_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;

   // request captured at transfer, plus the selected slot
   logic                          cmd_ff;
   logic [KEY_W-1:0]              key_ff;
   logic [frct_pkg::RANK_W-1:0]   rank_ff;
   logic                          sel_any_ff;
   logic [KEY_W-1:0]              sel_key_ff, sel_key_in;
   logic [COUNT_WIDTH-1:0]        sel_count_ff, sel_count_in;
   logic [IDX_W-1:0]              sel_idx_ff, sel_idx_in;

   // result register
   frct_pkg::frct_status_type     rsp_status_ff, rsp_status_in;
   logic [frct_pkg::POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [KEY_W-1:0]              rsp_key_ff, rsp_key_in;
   logic [frct_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [frct_pkg::FILL_OUT_W-1:0]  rsp_fill_ff;

   // cell row
   frct_pkg::frct_ctl_type        ctl;
   logic [DEPTH-1:0]              cell_sel;
   logic [DEPTH-1:0]              cell_dst;
   logic [DEPTH:0]                chain_span;
   logic [KEY_W-1:0]              chain_key   [DEPTH+1];
   logic [COUNT_WIDTH-1:0]        chain_count [DEPTH+1];

   logic                          accept, rsp_free, go, full, key_zero;
   logic                          do_incr, do_ins;
   logic [COUNT_WIDTH-1:0]        inc_count, upd_count;
   logic [IDX_W-1:0]              dst_idx;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign go       = (state_ff == ST_UPD) && rsp_free;
   assign full     = fill_ff == FILL_W'(DEPTH);
   assign key_zero = key_ff == '0;

   // the shift cycle changes the table only for a hit or a new key with room
   assign do_incr = go && (cmd_ff == frct_pkg::CMD_COUNT) && !key_zero && sel_any_ff;
   assign do_ins  = go && (cmd_ff == frct_pkg::CMD_COUNT) && !key_zero && !sel_any_ff && !full;

   // saturating increment of the hit count
   assign inc_count = (sel_count_ff == '1) ? sel_count_ff : sel_count_ff + COUNT_WIDTH'(1);
   assign upd_count = sel_any_ff ? inc_count : COUNT_WIDTH'(1);

   assign ctl.look    = accept;
   assign ctl.is_read = req_cmd == frct_pkg::CMD_READ;
   assign ctl.upd     = do_incr || do_ins;
   assign ctl.insert  = do_ins;

   assign chain_span[0]  = 1'b0;
   assign chain_key[0]   = '0;
   assign chain_count[0] = '0;

   // each cell shifts from its upper neighbor, slot 0 holds the highest count
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      frct_cell #(
         .CELL_INDEX  (g),
         .DEPTH       (DEPTH),
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .req_key    (req_key),
         .req_rank   (req_rank),
         .fill       (fill_ff),
         .hit_idx    (sel_idx_ff),
         .new_key    (key_ff),
         .new_count  (upd_count),
         .prev_span  (chain_span[g]),
         .prev_key   (chain_key[g]),
         .prev_count (chain_count[g]),
         .sel        (cell_sel[g]),
         .span       (chain_span[g+1]),
         .dst        (cell_dst[g]),
         .key        (chain_key[g+1]),
         .count      (chain_count[g+1])
      );
   end

   // at most one cell is selected, so an or of masked entries picks it
   always_comb begin
      sel_key_in   = '0;
      sel_count_in = '0;
      sel_idx_in   = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_key_in   = sel_key_in   | ({KEY_W{cell_sel[i]}} & chain_key[i+1]);
         sel_count_in = sel_count_in | ({COUNT_WIDTH{cell_sel[i]}} & chain_count[i+1]);
         sel_idx_in   = sel_idx_in   | ({IDX_W{cell_sel[i]}} & IDX_W'(i));
      end
   end

   // binary position of the destination slot
   always_comb begin
      dst_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         dst_idx = dst_idx | ({IDX_W{cell_dst[i]}} & IDX_W'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= req_cmd;
         key_ff       <= req_key;
         rank_ff      <= req_rank;
         sel_any_ff   <= |cell_sel;
         sel_key_ff   <= sel_key_in;
         sel_count_ff <= sel_count_in;
         sel_idx_ff   <= sel_idx_in;
      end
   end

   // result fields for the request in the shift cycle
   always_comb begin
      rsp_status_in = frct_pkg::STATUS_EMPTY;
      rsp_pos_in    = '0;
      rsp_key_in    = '0;
      rsp_count_in  = '0;
      priority if (cmd_ff == frct_pkg::CMD_READ) begin
         rsp_pos_in = rank_ff;
         if (sel_any_ff) begin
            rsp_status_in = frct_pkg::STATUS_READ_OK;
            rsp_key_in    = sel_key_ff;
            rsp_count_in  = frct_pkg::COUNT_OUT_W'(sel_count_ff);
         end else begin
            rsp_status_in = frct_pkg::STATUS_BEYOND;
         end
      end else if (key_zero) begin
         rsp_status_in = frct_pkg::STATUS_EMPTY;
      end else if (sel_any_ff) begin
         rsp_status_in = frct_pkg::STATUS_INCR;
         rsp_pos_in    = frct_pkg::POS_W'(dst_idx);
         rsp_key_in    = key_ff;
         rsp_count_in  = frct_pkg::COUNT_OUT_W'(inc_count);
      end else if (full) begin
         rsp_status_in = frct_pkg::STATUS_FULL;
      end else begin
         rsp_status_in = frct_pkg::STATUS_INSERTED;
         rsp_pos_in    = frct_pkg::POS_W'(dst_idx);
         rsp_key_in    = key_ff;
         rsp_count_in  = frct_pkg::COUNT_OUT_W'(COUNT_WIDTH'(1));
      end
   end

   assign fill_in = do_ins ? fill_ff + FILL_W'(1) : fill_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // a new result replaces the one taken in the same cycle
   assign rsp_valid_in = go ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         if (go) begin
            rsp_status_ff <= rsp_status_in;
            rsp_pos_ff    <= rsp_pos_in;
            rsp_key_ff    <= rsp_key_in;
            rsp_count_ff  <= rsp_count_in;
            rsp_fill_ff   <= frct_pkg::FILL_OUT_W'(fill_in);
         end
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{frct_pkg::RSP_PAD_W{1'b0}}, rsp_fill_ff, rsp_count_ff,
                        rsp_key_ff, rsp_pos_ff};

   // checks

   `FRCT_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(DEPTH), "fill level above table depth")

   `FRCT_ASSERT_IMP(a_sel_unique, clock, reset, ctl.look, $onehot0(cell_sel), "more than one cell selected by a transfer")

   `FRCT_ASSERT_IMP(a_dst_unique, clock, reset, ctl.upd, $countones(cell_dst) == 1, "shift without exactly one destination slot")

   `FRCT_ASSERT_NXT(a_accept_to_upd, clock, reset, accept, state_ff == ST_UPD, "request transfer not followed by shift cycle")

   `FRCT_ASSERT_IMP(a_rsp_from_upd, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_UPD), "result raised outside shift cycle")

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: frequency ranked counter table unit testbench
// drives count and read requests and compares every result transfer against a
// hand-written result for typed rows, else an in-bench model of the ranked key table
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = frct_pkg::DEPTH_DEFAULT;
   localparam int CNT_W       = frct_pkg::COUNT_WIDTH_DEFAULT;
   localparam int PHASE_ITEMS = 425;
   localparam int HOLD_CYCLES = 80;
   localparam int DIR_ROWS    = 25;

   typedef struct packed {
      frct_pkg::frct_status_type               st;
      logic [frct_pkg::POS_W-1:0]              pos;
      logic [frct_pkg::KEY_W-1:0]              key;
      logic [frct_pkg::COUNT_OUT_W-1:0]        cnt;
      logic [frct_pkg::FILL_OUT_W-1:0]         fill;
   } tally_res_type;

   typedef struct packed {
      logic                                    cmd;
      logic [frct_pkg::KEY_W-1:0]              key;
      logic [frct_pkg::RANK_W-1:0]             rank;
      logic                                    typed;   // result below is written out by hand
      tally_res_type                           want;
   } dir_row_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [frct_pkg::REQ_DATA_W-1:0]      req_tdata = '0;  // key[63:0], rank[67:64], zero pad
   logic [frct_pkg::CMD_W-1:0]           req_tuser = '0;  // command[0]
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [frct_pkg::RSP_DATA_W-1:0]      rsp_tdata;       // position[3:0], key_out[67:4],
                                                          // count_out[99:68],
                                                          // fill_out[104:100]
   logic [frct_pkg::STATUS_W-1:0]        rsp_tuser;       // status[2:0]

   // side band that travels with the request, seen by the monitor at transfer
   logic                                 note_typed = 1'b0;
   tally_res_type                        note_res   = '0;

   // ranked table model
   logic [frct_pkg::KEY_W-1:0]           rank_key [TABLE_DEPTH];
   logic [CNT_W-1:0]                     rank_cnt [TABLE_DEPTH];
   int                                   rank_fill;

   tally_res_type                        pending_res [$];
   int                                   err_cnt = 0;

   int                                   idle_pct  = 0;
   int                                   stall_pct = 0;
   logic                                 hold_ask  = 1'b0;
   int                                   hold_cnt  = 0;

   logic [frct_pkg::KEY_W-1:0]           key_pool [TABLE_DEPTH];
   dir_row_type                          dir_rows [DIR_ROWS];

   frequency_ranked_counter_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // move entry src up to dst, shifting the entries between down one rank
   function automatic void rank_lift(int src, int dst);
      logic [frct_pkg::KEY_W-1:0] k;
      logic [CNT_W-1:0]           c;
      k = rank_key[src];
      c = rank_cnt[src];
      for (int j = src; j > dst; j--) begin
         rank_key[j] = rank_key[j-1];
         rank_cnt[j] = rank_cnt[j-1];
      end
      rank_key[dst] = k;
      rank_cnt[dst] = c;
   endfunction

   // apply one request to the model table and return the result it causes
   function automatic tally_res_type tally_apply(logic cmd, logic [frct_pkg::KEY_W-1:0] key,
                                                 logic [frct_pkg::RANK_W-1:0] rank);
      tally_res_type r;
      int            hit;
      int            dst;
      logic          seen;
      r = '0;
      if (cmd == frct_pkg::CMD_READ) begin
         r.pos = rank;
         if (rank < rank_fill) begin
            r.st  = frct_pkg::STATUS_READ_OK;
            r.key = rank_key[rank];
            r.cnt = frct_pkg::COUNT_OUT_W'(rank_cnt[rank]);
         end else begin
            r.st = frct_pkg::STATUS_BEYOND;
         end
      end else if (key == '0) begin
         r.st = frct_pkg::STATUS_EMPTY;
      end else begin
         hit = -1;
         for (int i = 0; i < rank_fill; i++) begin
            if (hit < 0 && rank_key[i] == key) hit = i;
         end
         if (hit >= 0) begin
            // saturating increment, then climb past every entry it now matches
            if (rank_cnt[hit] != {CNT_W{1'b1}}) rank_cnt[hit] = rank_cnt[hit] + CNT_W'(1);
            dst  = hit;
            seen = 1'b0;
            for (int i = 0; i <= hit; i++) begin
               if (!seen && rank_cnt[hit] >= rank_cnt[i]) begin
                  dst  = i;
                  seen = 1'b1;
               end
            end
            rank_lift(hit, dst);
            r.st  = frct_pkg::STATUS_INCR;
            r.pos = frct_pkg::POS_W'(dst);
            r.key = rank_key[dst];
            r.cnt = frct_pkg::COUNT_OUT_W'(rank_cnt[dst]);
         end else if (rank_fill >= TABLE_DEPTH) begin
            r.st = frct_pkg::STATUS_FULL;
         end else begin
            // new key goes ahead of the first entry seen only once
            dst  = rank_fill;
            seen = 1'b0;
            for (int i = 0; i < rank_fill; i++) begin
               if (!seen && rank_cnt[i] == CNT_W'(1)) begin
                  dst  = i;
                  seen = 1'b1;
               end
            end
            rank_key[rank_fill] = key;
            rank_cnt[rank_fill] = CNT_W'(1);
            rank_lift(rank_fill, dst);
            rank_fill++;
            r.st  = frct_pkg::STATUS_INSERTED;
            r.pos = frct_pkg::POS_W'(dst);
            r.key = rank_key[dst];
            r.cnt = frct_pkg::COUNT_OUT_W'(rank_cnt[dst]);
         end
      end
      r.fill = rank_fill[frct_pkg::FILL_OUT_W-1:0];
      return r;
   endfunction

   // offer one request and return at the edge of its transfer
   task automatic send_req(logic cmd, logic [frct_pkg::KEY_W-1:0] key,
                           logic [frct_pkg::RANK_W-1:0] rank,
                           logic typed, tally_res_type want);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(frct_pkg::REQ_DATA_W-frct_pkg::KEY_W-frct_pkg::RANK_W){1'b0}},
                     rank, key};
      req_tuser  <= cmd;
      note_typed <= typed;
      note_res   <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   // one edge first so the monitor has queued the last request transfer
   task automatic drain_results;
      @(posedge clock);
      while (pending_res.size() != 0) @(posedge clock);
   endtask

   // result side: random stalls, plus one long hold-off when asked
   always @(posedge clock) begin
      if (hold_ask && hold_cnt < HOLD_CYCLES) begin
         hold_cnt   <= hold_cnt + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // request transfers feed the model, result transfers are checked in order
   always @(posedge clock) begin
      tally_res_type want;
      tally_res_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = tally_apply(req_tuser[0], req_tdata[frct_pkg::REQ_KEY_LO +: frct_pkg::KEY_W],
                               req_tdata[frct_pkg::REQ_RANK_LO +: frct_pkg::RANK_W]);
            if (note_typed) want = note_res;
            pending_res.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.st   = frct_pkg::frct_status_type'(rsp_tuser);
            got.pos  = rsp_tdata[0 +: frct_pkg::POS_W];
            got.key  = rsp_tdata[frct_pkg::POS_W +: frct_pkg::KEY_W];
            got.cnt  = rsp_tdata[frct_pkg::POS_W+frct_pkg::KEY_W +: frct_pkg::COUNT_OUT_W];
            got.fill = rsp_tdata[frct_pkg::POS_W+frct_pkg::KEY_W+frct_pkg::COUNT_OUT_W +:
                                 frct_pkg::FILL_OUT_W];
            if (pending_res.size() == 0) begin
               $error("result transfer with nothing pending");
               err_cnt++;
            end else begin
               want = pending_res.pop_front();
               if (got.st != want.st) begin
                  $error("status expected %0d got %0d", want.st, got.st);
                  err_cnt++;
               end
               if (got.pos != want.pos) begin
                  $error("position expected %0d got %0d", want.pos, got.pos);
                  err_cnt++;
               end
               if (got.key != want.key) begin
                  $error("key_out expected %h got %h", want.key, got.key);
                  err_cnt++;
               end
               if (got.cnt != want.cnt) begin
                  $error("count_out expected %0d got %0d", want.cnt, got.cnt);
                  err_cnt++;
               end
               if (got.fill != want.fill) begin
                  $error("fill_out expected %0d got %0d", want.fill, got.fill);
                  err_cnt++;
               end
            end
         end
      end
   end

   initial begin
      logic [frct_pkg::KEY_W-1:0]  key;
      logic [frct_pkg::RANK_W-1:0] rank;
      logic                        cmd;
      int                          sel;

      rank_fill = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         rank_key[i] = '0;
         rank_cnt[i] = '0;
      end

      dir_rows = '{
         // empty table: reads beyond fill, empty key, first insert
         '{frct_pkg::CMD_READ,  64'h0, 4'd0,  1'b1,
           '{frct_pkg::STATUS_BEYOND, 4'd0, 64'h0, 32'd0, 5'd0}},
         '{frct_pkg::CMD_READ,  64'h0, 4'd15, 1'b1,
           '{frct_pkg::STATUS_BEYOND, 4'd15, 64'h0, 32'd0, 5'd0}},
         '{frct_pkg::CMD_COUNT, 64'h0, 4'd0,  1'b1,
           '{frct_pkg::STATUS_EMPTY, 4'd0, 64'h0, 32'd0, 5'd0}},
         '{frct_pkg::CMD_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1,
           '{frct_pkg::STATUS_INSERTED, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 5'd1}},
         // insert ahead of a count of one, then increments with equal counts, then a read
         '{frct_pkg::CMD_COUNT, 64'h0000_0000_0000_0001, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'h0000_0000_0000_0001, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'hAAAA_AAAA_AAAA_AAAA, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_READ,  64'h0, 4'd1, 1'b0, '0},
         // fill the table to its depth
         '{frct_pkg::CMD_COUNT, 64'h5555_5555_5555_5555, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'h8000_0000_0000_0000, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'h0000_0000_0000_0002, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'h7FFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'h0123_4567_89AB_CDEF, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'hFEDC_BA98_7654_3210, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'h0000_0001_0000_0000, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'hFFFF_FFFF_0000_0000, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'h0000_0000_FFFF_FFFF, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'hC3C3_C3C3_C3C3_C3C3, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'h3C3C_3C3C_3C3C_3C3C, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'h0F0F_0F0F_0F0F_0F0F, 4'd0, 1'b0, '0},
         '{frct_pkg::CMD_COUNT, 64'hF0F0_F0F0_F0F0_F0F0, 4'd0, 1'b0, '0},
         // full table: new key rejected, empty key, read of the last rank
         '{frct_pkg::CMD_COUNT, 64'h1234_5678_9ABC_DEF0, 4'd0, 1'b1,
           '{frct_pkg::STATUS_FULL, 4'd0, 64'h0, 32'd0, 5'd16}},
         '{frct_pkg::CMD_COUNT, 64'h0, 4'd15, 1'b1,
           '{frct_pkg::STATUS_EMPTY, 4'd0, 64'h0, 32'd0, 5'd16}},
         '{frct_pkg::CMD_READ,  64'h0, 4'd15, 1'b0, '0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_req(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].rank,
                  dir_rows[i].typed, dir_rows[i].want);
      req_tvalid <= 1'b0;
      drain_results();
      key_pool = rank_key;

      // phases: no idling, idle sender, stalling receiver, both
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = (ph == 1) ? 73 : (ph == 3) ? 38 : 0;
         stall_pct <= (ph == 2) ? 73 : (ph == 3) ? 38 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 0 && n == 40) hold_ask <= 1'b1;
            sel  = $urandom_range(0, 99);
            rank = frct_pkg::RANK_W'($urandom_range(0, 15));
            key  = {$urandom, $urandom};
            cmd  = frct_pkg::CMD_COUNT;
            if (sel < 30) begin
               key = key_pool[$urandom_range(0, 3)];       // hot keys
            end else if (sel < 55) begin
               key = key_pool[$urandom_range(0, TABLE_DEPTH - 1)];
            end else if (sel < 85) begin
               cmd = frct_pkg::CMD_READ;
            end else if (sel >= 95) begin
               key = '0;
            end
            send_req(cmd, key, rank, 1'b0, '0);
         end
         req_tvalid <= 1'b0;
         // sender waits for every pending result before the next phase
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (err_cnt == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
